// ===== design/bmm_pkg.sv =====
package bmm_pkg;

  typedef enum logic [3:0] {
    FUNC_RD_MAP   = 4'd0,
    FUNC_WR_MAP   = 4'd1,
    FUNC_RD_HIGH  = 4'd2,
    FUNC_WR_HIGH  = 4'd3,
    FUNC_RD_OAM   = 4'd4,
    FUNC_WR_OAM   = 4'd5,
    FUNC_RD_VBANK = 4'd6,
    FUNC_RD_WBANK = 4'd7,
    FUNC_WR_VBANK = 4'd8,
    FUNC_WR_WBANK = 4'd9
  } func_e;

  typedef struct packed {
    logic mem_rd;
    logic mem_wr;
    logic high_rd;
    logic high_wr;
    logic vbank_wr;
    logic wbank_wr;
  } ctl_t;

  localparam logic [15:0] ROM_UPPER_START   = 16'h4000;
  localparam logic [15:0] VIDEO_START       = 16'h8000;
  localparam logic [15:0] EXT_START         = 16'hA000;
  localparam logic [15:0] WORK_START        = 16'hC000;
  localparam logic [15:0] WORK_BANKED_START = 16'hD000;
  localparam logic [15:0] UNMAPPED_START    = 16'hE000;
  localparam logic [15:0] OAM_START         = 16'hFE00;

  localparam int ROM_FIXED_BASE = 'h0000;
  localparam int ROM_UPPER_BASE = 'h4000;
  localparam int EXT_BASE       = 'h8000;
  localparam int VIDEO_BASE     = 'hA000;
  localparam int VIDEO_BANK_SZ  = 'h2000;
  localparam int WORK_BANK_SZ   = 'h1000;

  localparam logic [7:0] VBANK_SET_MASK = 8'hFE;
  localparam logic [7:0] WBANK_SEL_MASK = 8'h07;
  localparam logic [7:0] WBANK_MIN      = 8'h01;
  localparam logic [7:0] WBANK_RESET    = 8'h01;
  localparam logic [7:0] HIGH_RESET     = 8'hFF;

endpackage

// ===== design/bmm_if.sv =====
interface bmm_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] func;
  logic [15:0] address;
  logic [7:0] write_data;

  modport source (output valid, output func, output address, output write_data, input ready);
  modport sink (input valid, input func, input address, input write_data, output ready);
endinterface

interface bmm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

// ===== design/bmm_ram.sv =====
module bmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bmm_decode.sv =====
module bmm_decode import bmm_pkg::*; #(
  parameter int VIDEO_BANKS  = 2,
  parameter int WORK_BANKS   = 8,
  parameter int SPRITE_BYTES = 160,
  parameter int HIGH_BYTES   = 256,
  parameter int AW           = 17
) (
  input  func_e         func_i,
  input  logic [15:0]   address_i,
  input  logic [7:0]    vbank_i,
  input  logic [7:0]    wbank_i,
  output ctl_t          ctl_o,
  output logic [AW-1:0] mem_addr_o,
  output logic [7:0]    reg_data_o
);

  localparam int WORK_BASE = VIDEO_BASE + VIDEO_BANKS * VIDEO_BANK_SZ;
  localparam int HIGH_BASE = WORK_BASE + WORK_BANKS * WORK_BANK_SZ;
  localparam int OAM_BASE  = HIGH_BASE + HIGH_BYTES;

  localparam logic [2:0] WMOD [8] = '{
    3'(0 % WORK_BANKS), 3'(1 % WORK_BANKS), 3'(2 % WORK_BANKS), 3'(3 % WORK_BANKS),
    3'(4 % WORK_BANKS), 3'(5 % WORK_BANKS), 3'(6 % WORK_BANKS), 3'(7 % WORK_BANKS)
  };

  logic        vsel;
  logic [2:0]  wsel;
  logic [15:0] oam_off;
  logic        oam_hit;
  logic        high_hit;
  logic        map_hit;
  logic [AW-1:0] map_addr;

  assign vsel     = (VIDEO_BANKS > 1) ? vbank_i[0] : 1'b0;
  assign wsel     = WMOD[wbank_i[2:0]];
  assign oam_off  = address_i - OAM_START;
  assign oam_hit  = oam_off < 16'(SPRITE_BYTES);
  assign high_hit = {1'b0, address_i[7:0]} < 9'(HIGH_BYTES);

  always_comb begin
    map_hit  = 1'b1;
    map_addr = '0;
    if (address_i < ROM_UPPER_START) begin
      map_addr = AW'(ROM_FIXED_BASE) + AW'(address_i[13:0]);
    end else if (address_i < VIDEO_START) begin
      map_addr = AW'(ROM_UPPER_BASE) + AW'(address_i[13:0]);
    end else if (address_i < EXT_START) begin
      map_addr = AW'(VIDEO_BASE) + AW'({vsel, address_i[12:0]});
    end else if (address_i < WORK_START) begin
      map_addr = AW'(EXT_BASE) + AW'(address_i[12:0]);
    end else if (address_i < WORK_BANKED_START) begin
      map_addr = AW'(WORK_BASE) + AW'(address_i[11:0]);
    end else if (address_i < UNMAPPED_START) begin
      map_addr = AW'(WORK_BASE) + AW'({wsel, address_i[11:0]});
    end else begin
      map_hit = 1'b0;
    end
  end

  always_comb begin
    ctl_o      = '0;
    mem_addr_o = map_addr;
    reg_data_o = '0;
    unique case (func_i)
      FUNC_RD_MAP: ctl_o.mem_rd = map_hit;
      FUNC_WR_MAP: ctl_o.mem_wr = map_hit;
      FUNC_RD_HIGH: begin
        ctl_o.mem_rd  = high_hit;
        ctl_o.high_rd = high_hit;
        mem_addr_o    = AW'(HIGH_BASE) + AW'(address_i[7:0]);
      end
      FUNC_WR_HIGH: begin
        ctl_o.mem_wr  = high_hit;
        ctl_o.high_wr = high_hit;
        mem_addr_o    = AW'(HIGH_BASE) + AW'(address_i[7:0]);
      end
      FUNC_RD_OAM: begin
        ctl_o.mem_rd = oam_hit;
        mem_addr_o   = AW'(OAM_BASE) + AW'(oam_off[7:0]);
      end
      FUNC_WR_OAM: begin
        ctl_o.mem_wr = oam_hit;
        mem_addr_o   = AW'(OAM_BASE) + AW'(oam_off[7:0]);
      end
      FUNC_RD_VBANK: reg_data_o = vbank_i;
      FUNC_RD_WBANK: reg_data_o = wbank_i;
      FUNC_WR_VBANK: ctl_o.vbank_wr = 1'b1;
      FUNC_WR_WBANK: ctl_o.wbank_wr = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== design/banked_memory_map_unit_core.sv =====
// Memory map unit with banked video and work RAM. Each request beat carries one
// bus access and produces exactly one response beat with the byte read, or zero
// for writes, unmapped addresses and out-of-range sprite or high RAM offsets.
// All storage (both ROM areas, external, video and work RAM, high RAM and sprite
// memory) sits in one single-port RAM with a registered read; a request passes
// through the s1 stage and the output register, a new beat can be taken every
// cycle while the response side keeps up, and the RAM port is the one shared
// resource. After reset the block clears all VIDEO_BANKS * 8192 bytes of video
// RAM (16384 by default) and holds ready low during that pass. High RAM reads as
// 0xFF until an entry is written. Bank register writes take effect for the
// very next beat.
module banked_memory_map_unit_core import bmm_pkg::*; #(
  parameter int VIDEO_BANKS  = 2,
  parameter int WORK_BANKS   = 8,
  parameter int SPRITE_BYTES = 160,
  parameter int HIGH_BYTES   = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  bmm_req_if.sink    req_i,
  bmm_rsp_if.source  rsp_o
);

  localparam int WORK_BASE = VIDEO_BASE + VIDEO_BANKS * VIDEO_BANK_SZ;
  localparam int DEPTH     = WORK_BASE + WORK_BANKS * WORK_BANK_SZ + HIGH_BYTES + SPRITE_BYTES;
  localparam int AW        = $clog2(DEPTH);
  localparam int CLR_LEN   = VIDEO_BANKS * VIDEO_BANK_SZ;
  localparam int CW        = $clog2(CLR_LEN);
  localparam int HIW       = $clog2(HIGH_BYTES);

  ctl_t          ctl;
  logic [AW-1:0] dec_addr;
  logic [7:0]    reg_data;
  logic          accept;
  logic          s1_adv;

  logic          clearing_q, clearing_d;
  logic [CW-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]    vbank_q, vbank_d;
  logic [7:0]    wbank_q, wbank_d;
  logic [HIGH_BYTES-1:0] hvalid_q, hvalid_d;

  logic          s1_valid_q, s1_valid_d;
  logic          s1_mem_q, s1_mem_d;
  logic          s1_fill_q, s1_fill_d;
  logic [7:0]    s1_data_q, s1_data_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q, out_data_d;

  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  bmm_decode #(
    .VIDEO_BANKS  (VIDEO_BANKS),
    .WORK_BANKS   (WORK_BANKS),
    .SPRITE_BYTES (SPRITE_BYTES),
    .HIGH_BYTES   (HIGH_BYTES),
    .AW           (AW)
  ) u_decode (
    .func_i     (func_e'(req_i.func)),
    .address_i  (req_i.address),
    .vbank_i    (vbank_q),
    .wbank_i    (wbank_q),
    .ctl_o      (ctl),
    .mem_addr_o (dec_addr),
    .reg_data_o (reg_data)
  );

  bmm_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

  always_comb begin
    if (clearing_q) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = AW'(VIDEO_BASE) + AW'(clr_cnt_q);
      ram_wdata = '0;
    end else begin
      ram_en    = accept && (ctl.mem_rd || ctl.mem_wr);
      ram_we    = ctl.mem_wr;
      ram_addr  = dec_addr;
      ram_wdata = req_i.write_data;
    end
  end

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + CW'(1);
      if (clr_cnt_q == CW'(CLR_LEN - 1)) begin
        clearing_d = 1'b0;
      end
    end

    vbank_d  = vbank_q;
    wbank_d  = wbank_q;
    hvalid_d = hvalid_q;
    if (accept && ctl.vbank_wr) begin
      vbank_d = req_i.write_data | VBANK_SET_MASK;
    end
    if (accept && ctl.wbank_wr) begin
      wbank_d = req_i.write_data;
      if ((req_i.write_data & WBANK_SEL_MASK) == '0) begin
        wbank_d = req_i.write_data | WBANK_MIN;
      end
    end
    if (accept && ctl.high_wr) begin
      hvalid_d[req_i.address[HIW-1:0]] = 1'b1;
    end

    s1_valid_d = s1_valid_q;
    s1_mem_d   = s1_mem_q;
    s1_fill_d  = s1_fill_q;
    s1_data_d  = s1_data_q;
    if (accept) begin
      s1_valid_d = 1'b1;
      s1_mem_d   = ctl.mem_rd;
      s1_fill_d  = ctl.high_rd && !hvalid_q[req_i.address[HIW-1:0]];
      s1_data_d  = reg_data;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s1_adv && s1_valid_q) begin
      out_valid_d = 1'b1;
      if (!s1_mem_q) begin
        out_data_d = s1_data_q;
      end else if (s1_fill_q) begin
        out_data_d = HIGH_RESET;
      end else begin
        out_data_d = ram_rdata;
      end
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      vbank_q     <= '0;
      wbank_q     <= WBANK_RESET;
      hvalid_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      vbank_q     <= vbank_d;
      wbank_q     <= wbank_d;
      hvalid_q    <= hvalid_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mem_q   <= s1_mem_d;
    s1_fill_q  <= s1_fill_d;
    s1_data_q  <= s1_data_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== design/bmm_checker.sv =====
module bmm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_data_i
);

  logic req_beat;
  assign req_beat = req_valid_i && req_ready_i;

  rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("stalled response beat dropped or changed");

  rsp_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_beat, 2))
    else $error("response beat appeared without a request two cycles before");

  clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !req_ready_i)
    else $error("request accepted before video RAM was cleared");

  one_in_flight_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat && rsp_valid_i && !rsp_ready_i |=> !req_ready_i || rsp_ready_i)
    else $error("more requests taken than the pipeline can hold");

endmodule

bind banked_memory_map_unit_core bmm_checker u_bmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.read_data)
);

// ===== tb/sv/bmm_map_checker.sv =====
module bmm_map_checker import bmm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bmm_req_if   req_i,
  bmm_rsp_if   rsp_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o
);

  localparam int RomUpperBase = 'h4000;
  localparam int VramBase     = 'h8000;
  localparam int XramBase     = 'hC000;
  localparam int WramBase     = 'hE000;
  localparam int MapBytes     = 'h16000;
  localparam int SpriteBytes  = 160;
  localparam int HighBytes    = 256;

  logic [7:0] map_mem [MapBytes];
  logic [7:0] sprite_mem [SpriteBytes];
  logic [7:0] high_mem [HighBytes];
  logic [7:0] vram_bank_q;
  logic [7:0] wram_bank_q;
  logic [7:0] read_data_q [$];
  logic [7:0] want;
  int mismatch_count = 0;
  int checked_count = 0;

  // Flat index into map_mem for a bus address under the current bank
  // selections, or -1 at the unmapped top of the map.
  function automatic int map_index(input logic [15:0] addr);
    if (addr < ROM_UPPER_START) return int'(addr[13:0]);
    if (addr < VIDEO_START) return RomUpperBase + int'(addr[13:0]);
    if (addr < EXT_START) return VramBase + int'({vram_bank_q[0], addr[12:0]});
    if (addr < WORK_START) return XramBase + int'(addr[12:0]);
    if (addr < WORK_BANKED_START) return WramBase + int'(addr[11:0]);
    if (addr < UNMAPPED_START) return WramBase + int'({wram_bank_q[2:0], addr[11:0]});
    return -1;
  endfunction

  function automatic void clear_model();
    int i;
    for (i = 0; i < MapBytes; i++) map_mem[i] = 8'h00;
    for (i = 0; i < SpriteBytes; i++) sprite_mem[i] = 8'h00;
    for (i = 0; i < HighBytes; i++) high_mem[i] = HIGH_RESET;
    vram_bank_q = 8'h00;
    wram_bank_q = WBANK_RESET;
  endfunction

  function automatic logic [7:0] apply_access(input logic [3:0] code, input logic [15:0] addr,
                                              input logic [7:0] wdata);
    int idx;
    logic [15:0] off;
    logic [7:0] rdata;
    idx = map_index(addr);
    off = addr - OAM_START;
    rdata = 8'h00;
    case (code)
      FUNC_RD_MAP: if (idx >= 0) rdata = map_mem[idx];
      FUNC_WR_MAP: if (idx >= 0) map_mem[idx] = wdata;
      FUNC_RD_HIGH: rdata = high_mem[addr[7:0]];
      FUNC_WR_HIGH: high_mem[addr[7:0]] = wdata;
      FUNC_RD_OAM: if (off < 16'(SpriteBytes)) rdata = sprite_mem[off[7:0]];
      FUNC_WR_OAM: if (off < 16'(SpriteBytes)) sprite_mem[off[7:0]] = wdata;
      FUNC_RD_VBANK: rdata = vram_bank_q;
      FUNC_RD_WBANK: rdata = wram_bank_q;
      FUNC_WR_VBANK: vram_bank_q = wdata | VBANK_SET_MASK;
      FUNC_WR_WBANK: begin
        // Bank 0 can never be selected for the banked window.
        if ((wdata & WBANK_SEL_MASK) == 8'h00) wram_bank_q = wdata | WBANK_MIN;
        else wram_bank_q = wdata;
      end
      default: ;
    endcase
    return rdata;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want_byte);
    $display("%0t mismatch: %s, read_data %h, predicted %h", $time, what, got, want_byte);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      read_data_q.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        read_data_q.push_back(apply_access(req_i.func, req_i.address, req_i.write_data));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (read_data_q.size() == 0) begin
          report_mismatch("response beat with no access outstanding", rsp_i.read_data, 8'h00);
        end else begin
          want = read_data_q.pop_front();
          checked_count++;
          if (rsp_i.read_data !== want) begin
            report_mismatch("read_data differs", rsp_i.read_data, want);
          end
        end
      end
    end
    mismatches_o <= mismatch_count;
    pending_o <= read_data_q.size();
    checked_o <= checked_count;
  end

endmodule

// ===== tb/sv/banked_memory_map_unit_core_test.sv =====
module banked_memory_map_unit_core_test;
  import bmm_pkg::*;

  localparam int HalfPeriod = 5;
  localparam int RandomAccesses = 380;
  localparam int OamBytes = 160;
  localparam int HistoryDepth = 64;
  localparam logic [3:0] FUNC_UNUSED_LO = 4'd10;
  localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;

  logic clk_i;
  logic rst_ni;

  bmm_req_if req_bus();
  bmm_rsp_if rsp_bus();

  int mismatches;
  int pending;
  int checked;

  int req_calm = 0;
  int rsp_calm = 0;
  int beats_per_code [16];
  int unused_beats = 0;
  int sent_beats = 0;
  logic [7:0] wbank_val = WBANK_RESET;
  bit written_slot [int];
  logic [15:0] map_history [$];
  logic [15:0] oam_history [$];

  banked_memory_map_unit_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  bmm_map_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_i       (rsp_bus),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 32);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Storage that is undefined after reset must never be read before it is
  // written, so the stimulus tracks written locations by physical slot.
  function automatic int undefined_slot(input logic [15:0] addr);
    if (addr < VIDEO_START) return int'(addr);
    if (addr < EXT_START) return -1;
    if (addr < WORK_BANKED_START) return int'(addr);
    if (addr < UNMAPPED_START) return 'h10000 + int'({wbank_val[2:0], addr[11:0]});
    return -1;
  endfunction

  function automatic int sprite_slot(input logic [15:0] addr);
    logic [15:0] off;
    off = addr - OAM_START;
    if (off < 16'(OamBytes)) return 'h20000 + int'(off);
    return -1;
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] random_map_addr();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 'h3FFF));
      1: return ROM_UPPER_START + 16'($urandom_range(0, 'h3FFF));
      2: return VIDEO_START + 16'($urandom_range(0, 'h1FFF));
      3: return EXT_START + 16'($urandom_range(0, 'h1FFF));
      4: return WORK_START + 16'($urandom_range(0, 'hFFF));
      5: return WORK_BANKED_START + 16'($urandom_range(0, 'hFFF));
      6: return UNMAPPED_START + 16'($urandom_range(0, 'h1FFF));
      default: return 16'($urandom_range(0, 'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] readable_map_addr();
    logic [15:0] a;
    int s;
    int tries;
    for (tries = 0; tries < 8; tries++) begin
      if (map_history.size() > 0 && $urandom_range(0, 3) != 0) begin
        a = map_history[$urandom_range(0, map_history.size() - 1)];
      end else begin
        a = 16'($urandom_range(0, 'hFFFF));
      end
      s = undefined_slot(a);
      if (s < 0 || written_slot.exists(s)) return a;
    end
    return VIDEO_START + 16'($urandom_range(0, 'h1FFF));
  endfunction

  function automatic logic [15:0] random_oam_addr();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 'hFFFF));
      default: return OAM_START + 16'($urandom_range(0, 191));
    endcase
  endfunction

  function automatic logic [15:0] readable_oam_addr();
    logic [15:0] a;
    int s;
    int tries;
    for (tries = 0; tries < 8; tries++) begin
      if (oam_history.size() > 0 && $urandom_range(0, 3) != 0) begin
        a = oam_history[$urandom_range(0, oam_history.size() - 1)];
      end else begin
        a = random_oam_addr();
      end
      s = sprite_slot(a);
      if (s < 0 || written_slot.exists(s)) return a;
    end
    return OAM_START + 16'(OamBytes) + 16'($urandom_range(0, 95));
  endfunction

  task automatic send_beat(input logic [3:0] code, input logic [15:0] addr,
                           input logic [7:0] wdata);
    int gap;
    int slot;
    gap = draw_gap(req_calm);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.func <= code;
    req_bus.address <= addr;
    req_bus.write_data <= wdata;
    do @(posedge clk_i); while (!req_bus.ready);
    sent_beats++;
    beats_per_code[code]++;
    if (code > FUNC_WR_WBANK) unused_beats++;
    case (code)
      FUNC_WR_MAP: begin
        slot = undefined_slot(addr);
        if (slot >= 0) written_slot[slot] = 1'b1;
        map_history.push_back(addr);
        if (map_history.size() > HistoryDepth) void'(map_history.pop_front());
      end
      FUNC_WR_OAM: begin
        slot = sprite_slot(addr);
        if (slot >= 0) begin
          written_slot[slot] = 1'b1;
          oam_history.push_back(addr);
          if (oam_history.size() > HistoryDepth) void'(oam_history.pop_front());
        end
      end
      FUNC_WR_WBANK: begin
        if ((wdata & WBANK_SEL_MASK) == 8'h00) wbank_val = wdata | WBANK_MIN;
        else wbank_val = wdata;
      end
      default: ;
    endcase
  endtask

  initial begin
    int stall;
    rsp_bus.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = draw_gap(rsp_calm);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_bus.valid);
    end
  end

  initial begin
    int n;
    int pick;
    int drain;
    logic [15:0] a;
    rst_ni <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.func <= FUNC_RD_MAP;
    req_bus.address <= 16'h0000;
    req_bus.write_data <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(FUNC_WR_MAP, 16'h0000, 8'hFF);
    send_beat(FUNC_WR_MAP, 16'h7FFF, 8'h00);
    send_beat(FUNC_RD_MAP, 16'h0000, 8'h00);
    send_beat(FUNC_RD_MAP, 16'h7FFF, 8'hFF);
    send_beat(FUNC_RD_MAP, VIDEO_START, 8'h00);
    send_beat(FUNC_WR_VBANK, 16'h0000, 8'h01);
    send_beat(FUNC_RD_VBANK, 16'hFFFF, 8'h00);
    send_beat(FUNC_WR_MAP, 16'h9FFF, 8'hA5);
    send_beat(FUNC_RD_MAP, 16'h9FFF, 8'h00);
    send_beat(FUNC_WR_VBANK, 16'h0000, 8'h00);
    send_beat(FUNC_RD_MAP, 16'h9FFF, 8'h00);
    send_beat(FUNC_WR_MAP, 16'hBFFF, 8'h5A);
    send_beat(FUNC_RD_MAP, 16'hBFFF, 8'h00);
    send_beat(FUNC_WR_WBANK, 16'h0000, 8'hF8);
    send_beat(FUNC_RD_WBANK, 16'h0000, 8'h00);
    send_beat(FUNC_WR_WBANK, 16'h0000, 8'h07);
    send_beat(FUNC_WR_MAP, WORK_BANKED_START, 8'hC3);
    send_beat(FUNC_RD_MAP, WORK_BANKED_START, 8'h00);
    send_beat(FUNC_WR_MAP, UNMAPPED_START, 8'h77);
    send_beat(FUNC_RD_MAP, 16'hFFFF, 8'h00);
    send_beat(FUNC_RD_HIGH, 16'h00FF, 8'h00);
    send_beat(FUNC_WR_HIGH, 16'hFF80, 8'h12);
    send_beat(FUNC_RD_HIGH, 16'h1280, 8'h00);
    send_beat(FUNC_WR_OAM, 16'hFE9F, 8'h99);
    send_beat(FUNC_RD_OAM, 16'hFE9F, 8'h00);
    send_beat(FUNC_WR_OAM, 16'hFEA0, 8'h11);
    send_beat(FUNC_RD_OAM, 16'hFEA0, 8'h00);
    send_beat(FUNC_RD_OAM, 16'h0000, 8'h00);
    send_beat(FUNC_UNUSED_HI, 16'hFFFF, 8'hFF);

    for (n = 0; n < RandomAccesses; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_beat(FUNC_WR_MAP, random_map_addr(), random_byte());
      end else if (pick < 47) begin
        send_beat(FUNC_RD_MAP, readable_map_addr(), random_byte());
      end else if (pick < 53) begin
        a = random_map_addr();
        send_beat(FUNC_WR_MAP, a, random_byte());
        send_beat(FUNC_RD_MAP, a, random_byte());
      end else if (pick < 59) begin
        send_beat(FUNC_WR_HIGH, 16'($urandom_range(0, 'hFFFF)), random_byte());
      end else if (pick < 65) begin
        send_beat(FUNC_RD_HIGH, 16'($urandom_range(0, 'hFFFF)), random_byte());
      end else if (pick < 71) begin
        send_beat(FUNC_WR_OAM, random_oam_addr(), random_byte());
      end else if (pick < 77) begin
        send_beat(FUNC_RD_OAM, readable_oam_addr(), random_byte());
      end else if (pick < 81) begin
        send_beat(FUNC_WR_VBANK, 16'($urandom_range(0, 'hFFFF)), random_byte());
      end else if (pick < 85) begin
        send_beat(FUNC_WR_WBANK, 16'($urandom_range(0, 'hFFFF)), random_byte());
      end else if (pick < 89) begin
        send_beat(FUNC_RD_VBANK, 16'($urandom_range(0, 'hFFFF)), random_byte());
      end else if (pick < 93) begin
        send_beat(FUNC_RD_WBANK, 16'($urandom_range(0, 'hFFFF)), random_byte());
      end else if (pick < 96) begin
        send_beat(4'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)),
                  16'($urandom_range(0, 'hFFFF)), random_byte());
      end else begin
        send_beat(FUNC_WR_WBANK, 16'($urandom_range(0, 'hFFFF)), random_byte());
        a = WORK_BANKED_START + 16'($urandom_range(0, 'hFFF));
        send_beat(FUNC_WR_MAP, a, random_byte());
        send_beat(FUNC_RD_MAP, a, random_byte());
      end
    end

    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    drain = 0;
    while (pending != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    $display("Sent %0d accesses: %0d map writes, %0d map reads, %0d high RAM,",
             sent_beats, beats_per_code[FUNC_WR_MAP], beats_per_code[FUNC_RD_MAP],
             beats_per_code[FUNC_RD_HIGH] + beats_per_code[FUNC_WR_HIGH]);
    $display("%0d sprite and %0d unused; checked %0d read_data beats, %0d mismatches, %0d left",
             beats_per_code[FUNC_RD_OAM] + beats_per_code[FUNC_WR_OAM], unused_beats,
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out waiting for handshakes");
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bmm_pkg.sv
design/bmm_if.sv
design/bmm_ram.sv
design/bmm_decode.sv
design/banked_memory_map_unit_core.sv
design/bmm_checker.sv
tb/sv/bmm_map_checker.sv
tb/sv/banked_memory_map_unit_core_test.sv
